[sv/bfa_pkg.sv]
`default_nettype none

package bfa_pkg;

  // Field widths of the item types and the size register
  localparam int INDEX_W = 10;
  localparam int SIZE_W  = 11;

  // Highest number of entries the index fields can name
  localparam int INDEX_LIMIT = 1024;

  // Map storage: one memory word holds WORD_BITS entries
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  // Size register after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    MODE_RESERVE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_SET     = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [INDEX_W-1:0] entry_index;
  } req_item_t;

  typedef struct packed {
    logic               status;
    logic [INDEX_W-1:0] granted_index;
    logic               bit_value;
  } rsp_item_t;

endpackage

`default_nettype wire

[sv/bitmap_first_free_allocator_unit.sv]
// First-fit bitmap allocator.
// Request channel (req_valid / req_stall / req) carries an operation and an
// entry index; the response channel (rsp_valid / rsp_stall / rsp) returns one
// item per request: status, granted index and bit value.
// cfg_write / cfg_data load the map size; write it only while the unit is idle.
// Sequence: a request accepted in idle moves to a search state, where the
// map word is read, then to a finish state, where the operation is evaluated
// and the response register loaded; the next request is taken as soon as the
// unit is back in idle. This follows from the map memory: one registered
// read, then one write back. Reserve does not scan words: a full flag per map
// word picks the first word with room, and that word is searched in one go.
// Reset clears the map through a valid bit per word and sets the size to 1024;
// no clearing pass is needed, requests are taken from the first cycle on.
// When the receiver stalls, the response stays in its register; a further
// request is still accepted and worked up to the finish cycle, where it waits
// until the response register frees up.
`default_nettype none

module bitmap_first_free_allocator_unit
  import bfa_pkg::*;
#(
  parameter int MAX_BITS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_item_t         req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_item_t              rsp,
  input  wire logic              cfg_write,
  input  wire logic [SIZE_W-1:0] cfg_data
);

  // Entries beyond the index range are never used
  localparam int USED_BITS = (MAX_BITS < INDEX_LIMIT) ? MAX_BITS : INDEX_LIMIT;
  localparam int NUM_WORDS = (USED_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WUSE_W    = SIZE_W + 1 - BIT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t               state;
  mode_t                op_mode;
  logic [INDEX_W-1:0]   op_index;
  logic [SIZE_W-1:0]    op_size;
  logic [WADDR_W-1:0]   op_addr;
  logic                 op_hit;
  logic [SIZE_W-1:0]    map_size;
  logic [NUM_WORDS-1:0] full;
  logic [NUM_WORDS-1:0] word_vld;
  logic                 rd_vld;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] map_mem [NUM_WORDS];

  logic [SIZE_W-1:0]    size_eff;
  logic                 req_take;
  logic                 rsp_free;
  logic                 finish_go;

  logic [WUSE_W-1:0]    words_in_use;
  logic [NUM_WORDS-1:0] word_cand;
  logic [NUM_WORDS-1:0] word_low;
  logic [WADDR_W-1:0]   search_addr;
  logic                 search_hit;

  logic [WORD_BITS-1:0] cur_word;
  logic [BIT_W-1:0]     bit_sel;
  logic                 cur_bit;
  logic                 in_range;
  logic [WORD_BITS-1:0] free_ok;
  logic [WORD_BITS-1:0] free_low;
  logic [BIT_W-1:0]     free_bit;
  logic                 write_ok;
  logic                 map_we;
  logic [WORD_BITS-1:0] new_word;
  rsp_item_t            rsp_next;

  // Handshakes
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign finish_go = (state == ST_FINISH) && rsp_free;

  // Size in use, limited to the map
  assign size_eff = (map_size > SIZE_W'(USED_BITS)) ? SIZE_W'(USED_BITS) : map_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= SIZE_RESET;
    end else if (cfg_write) begin
      map_size <= cfg_data;
    end
  end

  // Word to read: first word with room for reserve, else the word of the entry
  always_comb begin
    words_in_use = WUSE_W'(({1'b0, op_size} + (SIZE_W + 1)'(WORD_BITS - 1)) >> BIT_W);
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_cand[w] = !full[w] && (WUSE_W'(w) < words_in_use);
    end
    word_low    = word_cand & (~word_cand + NUM_WORDS'(1));
    search_addr = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (word_low[w]) begin
        search_addr = search_addr | WADDR_W'(w);
      end
    end
    search_hit = |word_cand;
    if (op_mode != MODE_RESERVE) begin
      search_addr = WADDR_W'(op_index >> BIT_W);
    end
  end

  // Finish: evaluate the operation on the word read
  always_comb begin
    cur_word = rd_vld ? rd_data : '0;
    bit_sel  = op_index[BIT_W-1:0];
    cur_bit  = cur_word[bit_sel];
    in_range = ({1'b0, op_index} < op_size);

    for (int b = 0; b < WORD_BITS; b++) begin
      free_ok[b] = !cur_word[b] && (SIZE_W'({op_addr, BIT_W'(b)}) < op_size);
    end
    free_low = free_ok & (~free_ok + WORD_BITS'(1));
    free_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (free_low[b]) begin
        free_bit = free_bit | BIT_W'(b);
      end
    end

    rsp_next        = '0;
    rsp_next.status = 1'b1;
    new_word        = cur_word;
    write_ok        = 1'b0;
    unique case (op_mode)
      MODE_RESERVE: begin
        if (op_hit && (|free_ok)) begin
          new_word               = cur_word | free_low;
          rsp_next.status        = 1'b0;
          rsp_next.granted_index = INDEX_W'({op_addr, free_bit});
          write_ok               = 1'b1;
        end
      end
      MODE_RELEASE: begin
        if (in_range && cur_bit) begin
          new_word        = cur_word & ~(WORD_BITS'(1) << bit_sel);
          rsp_next.status = 1'b0;
          write_ok        = 1'b1;
        end
      end
      MODE_SET: begin
        if (in_range && !cur_bit) begin
          new_word        = cur_word | (WORD_BITS'(1) << bit_sel);
          rsp_next.status = 1'b0;
          write_ok        = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (in_range) begin
          rsp_next.status    = 1'b0;
          rsp_next.bit_value = cur_bit;
        end
      end
      default: begin
        rsp_next.status = 1'b1;
      end
    endcase
    map_we = finish_go && write_ok;
  end

  // Map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[op_addr] <= new_word;
    end
    if (state == ST_SEARCH) begin
      rd_data <= map_mem[search_addr];
    end
  end

  // Sequencer, word flags and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      full      <= '0;
      word_vld  <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Response register: load on finish, drop once taken
      if (finish_go) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            op_mode  <= req.mode;
            op_index <= req.entry_index;
            op_size  <= size_eff;
            state    <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          op_addr <= search_addr;
          op_hit  <= search_hit;
          rd_vld  <= word_vld[search_addr];
          state   <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_free) begin
            state <= ST_IDLE;
            if (write_ok) begin
              word_vld[op_addr] <= 1'b1;
              full[op_addr]     <= &new_word;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Full flag tracks the word just written
  assert property (@(posedge clk) disable iff (rst)
    map_we |=> (full[$past(op_addr)] == $past(&new_word)))
    else $error("full flag does not match written map word");

  // A grant always lies below the size in use
  assert property (@(posedge clk) disable iff (rst)
    (finish_go && (op_mode == MODE_RESERVE) && !rsp_next.status)
      |-> (SIZE_W'(rsp_next.granted_index) < op_size))
    else $error("granted entry outside the map size");

  // The map changes only on a successful operation
  assert property (@(posedge clk) disable iff (rst)
    map_we |-> (!rsp_next.status && (op_mode != MODE_QUERY)))
    else $error("map written by a failed or read-only operation");

endmodule

`default_nettype wire
